// ----- src/urldec_pkg.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder package
// Beat payload types, character constants and the escape conversion function.
// ----------------------------------------------------------------------------
package urldec_pkg;

   localparam logic [7:0] PCT_CHAR   = 8'h25;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] MINUS_CHAR = 8'h2D;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [4:0] HEX_BASE   = 5'd16;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } urldec_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       out_last;
      logic       error;
   } urldec_rsp_type;

   // Digit value 0 to 15, or HEX_BASE when the character is not a hex digit.
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] v;
      begin
         v = HEX_BASE;
         if (c inside {[8'h30:8'h39]}) begin
            v = 5'(c - 8'h30);
         end else if (c inside {[8'h41:8'h46]}) begin
            v = 5'(c - 8'h41 + 8'd10);
         end else if (c inside {[8'h61:8'h66]}) begin
            v = 5'(c - 8'h61 + 8'd10);
         end
         return v;
      end
   endfunction

   function automatic logic is_white(input logic [7:0] c);
      return (c == SPACE_CHAR) || (c inside {[8'h09:8'h0D]});
   endfunction

   // Converts the two bytes after a percent sign as a base-16 strtol would.
   function automatic logic [7:0] convert_pair(input logic [7:0] a, input logic [7:0] b);
      logic [4:0] va;
      logic [4:0] vb;
      logic       b_hex;
      logic [7:0] v;
      begin
         va    = hex_val(a);
         vb    = hex_val(b);
         b_hex = (vb != HEX_BASE);
         v     = 8'd0;
         if (is_white(a) || a == PLUS_CHAR) begin
            v = b_hex ? {4'd0, vb[3:0]} : 8'd0;
         end else if (a == MINUS_CHAR) begin
            v = b_hex ? (8'd0 - {4'd0, vb[3:0]}) : 8'd0;
         end else if (va != HEX_BASE) begin
            v = b_hex ? {va[3:0], vb[3:0]} : {4'd0, va[3:0]};
         end
         return v;
      end
   endfunction

endpackage

// ----- src/urldec_stream_if.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder stream interface
// Valid and ready handshake carrying one payload beat.
// ----------------------------------------------------------------------------
interface urldec_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/urldec_pipe_reg.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder pipeline register
// One handshake register stage; it refills in the cycle it drains.
// ----------------------------------------------------------------------------
module urldec_pipe_reg #(
   parameter type data_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  data_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output data_type out_data
);

   logic     valid_ff;
   logic     valid_in;
   data_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// ----- src/urldec_core.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder core
// Escape phase tracking and per-byte decoding of the registered input beat.
// ----------------------------------------------------------------------------
module urldec_core
   import urldec_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  urldec_req_type in_data,
   input  logic           take,
   output logic           res_valid,
   output urldec_rsp_type res_data
);

   localparam logic [1:0] PHASE_IDLE   = 2'd0;
   localparam logic [1:0] PHASE_FIRST  = 2'd1;
   localparam logic [1:0] PHASE_SECOND = 2'd2;

   logic [1:0] phase_ff;
   logic [1:0] phase_in;
   logic [7:0] digit_ff;
   logic [7:0] digit_in;
   logic       emit;

   always_comb begin
      phase_in = PHASE_IDLE;
      digit_in = digit_ff;
      emit     = 1'b0;
      res_data = '{out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1, error: 1'b1};
      case (phase_ff)
         PHASE_FIRST: begin
            if (in_data.in_last) begin
               emit     = 1'b1;
               digit_in = 8'd0;
            end else begin
               digit_in = in_data.in_byte;
               phase_in = PHASE_SECOND;
            end
         end
         PHASE_SECOND: begin
            emit     = 1'b1;
            digit_in = 8'd0;
            res_data = '{out_byte: convert_pair(digit_ff, in_data.in_byte), has_byte: 1'b1,
                         out_last: in_data.in_last, error: 1'b0};
         end
         default: begin
            if (in_data.in_byte == PCT_CHAR) begin
               if (in_data.in_last) begin
                  emit     = 1'b1;
                  digit_in = 8'd0;
               end else begin
                  phase_in = PHASE_FIRST;
               end
            end else begin
               emit     = 1'b1;
               res_data = '{out_byte: (in_data.in_byte == PLUS_CHAR) ? SPACE_CHAR
                                                                    : in_data.in_byte,
                            has_byte: 1'b1, out_last: in_data.in_last, error: 1'b0};
            end
         end
      endcase
      res_valid = in_valid && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         digit_ff <= 8'd0;
      end else if (in_valid && take) begin
         phase_ff <= phase_in;
         digit_ff <= digit_in;
      end
   end

endmodule

// ----- src/url_percent_decoder.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder for URL-encoded strings: plus to space, percent escapes
// to bytes, and an error result for a string that ends inside an escape.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Beat contents
//  req_if    in         valid / ready        in_byte, in_last
//  rsp_if    out        valid / ready        out_byte, has_byte, out_last, error
//
//  One request beat is taken per cycle while rsp_if does not stall; a result
//  passes through the input register and then the result register.
//  A percent sign and the first byte after it give no result.
//  Reset is synchronous and clears both register stages and the escape phase.
//  A stall on rsp_if holds the result register, then the input register, and
//  then lowers req_if.ready.
// ----------------------------------------------------------------------------
module url_percent_decoder
   import urldec_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   urldec_stream_if.sink         req_if,
   urldec_stream_if.source       rsp_if
);

   logic           stage_valid;
   logic           core_take;
   urldec_req_type stage_data;
   logic           res_valid;
   urldec_rsp_type res_data;
   logic           res_ready;

   urldec_pipe_reg #(
      .data_type (urldec_req_type)
   ) u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (req_if.payload),
      .out_valid (stage_valid),
      .out_ready (core_take),
      .out_data  (stage_data)
   );

   urldec_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_data   (stage_data),
      .take      (core_take),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   assign core_take = res_ready;

   urldec_pipe_reg #(
      .data_type (urldec_rsp_type)
   ) u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res_data),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_if.payload)
   );

endmodule

// ----- src/urldec_checker.sv -----
// ----------------------------------------------------------------------------
// URL percent decoder checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module urldec_checker
   import urldec_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           req_ready,
   input logic           rsp_valid,
   input logic           rsp_ready,
   input urldec_rsp_type rsp_payload
);

   // A result beat waiting on a stalled sink keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error |->
         !rsp_payload.has_byte && rsp_payload.out_last && rsp_payload.out_byte == 8'd0)
      else $error("malformed error beat");

   a_byte_or_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.has_byte != rsp_payload.error)
      else $error("rsp beat carries neither a byte nor an error");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // With the result side empty the decoder must take a request beat.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with empty result register");

endmodule

bind url_percent_decoder urldec_checker u_urldec_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
